// ===== hdl/mfed_pkg.sv =====
// Package for the motor feedback enable detector.
// Holds item structs, window sizing constants and register index codes.
// No dependencies.
package mfed_pkg;

    localparam int WINDOW_LEN      = 4;
    localparam int CONFIRM_WINDOWS = 2;

    localparam int CODE_W   = 12;
    localparam int THRESH_W = 14;
    localparam int OFFSET_W = 32;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W   = $clog2(WINDOW_LEN + 1);
    localparam int CNT_W    = $clog2(CONFIRM_WINDOWS + 1);
    localparam int SUM_W    = CODE_W + $clog2(WINDOW_LEN);
    localparam int CMP_W    = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;

    localparam logic [6:0] FRAME_BYTES = 7'd8;

    typedef enum logic [1:0] {
        CFG_POSITION_OFFSET = 2'd0,
        CFG_WINDOW_SUM_THRESHOLD = 2'd1,
        CFG_DETECT_ENABLE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [63:0] frame_bytes;
        logic        id_extended;
        logic [6:0]  byte_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         motor_id;
        logic [15:0]        position_code;
        logic [11:0]        velocity_code;
        logic [11:0]        torque_code;
        logic [7:0]         temperature;
        logic [7:0]         error_code;
        logic signed [31:0] offset_position;
        logic               drive_active;
    } out_item_t;

    typedef struct packed {
        logic              strobe;
        logic [CODE_W-1:0] torque;
    } det_req_t;

endpackage

// ===== hdl/mfed_detect.sv =====
// Torque activity detector: sliding window of absolute torque-code deltas,
// running sum, threshold compare and confirmation count.
// Depends on mfed_pkg.
module mfed_detect import mfed_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  det_req_t            req,
    input  logic [THRESH_W-1:0] threshold,
    output logic                confirmed_next
);

    logic                have_prev_reg, have_prev_next;
    logic [CODE_W-1:0]   prev_reg, prev_next;
    logic [CODE_W-1:0]   win_reg [WINDOW_LEN];
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                flag_reg, flag_next;
    logic [CODE_W-1:0]   delta;
    logic                full;
    logic                win_we;

    always_comb begin
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        flag_next      = flag_reg;
        win_we         = 1'b0;
        full           = (fill_reg == FILL_W'(WINDOW_LEN));
        delta          = (req.torque >= prev_reg) ? (req.torque - prev_reg)
                                                  : (prev_reg - req.torque);
        if (req.strobe) begin
            prev_next      = req.torque;
            have_prev_next = 1'b1;
            if (have_prev_reg) begin
                win_we   = 1'b1;
                // drop the oldest delta once the window is full
                sum_next = sum_reg - (full ? SUM_W'(win_reg[idx_reg]) : '0)
                         + SUM_W'(delta);
                if (!full) begin
                    fill_next = fill_reg + 1'b1;
                end
                idx_next = (idx_reg == IDX_W'(WINDOW_LEN - 1)) ? '0 : idx_reg + 1'b1;
                if (fill_next == FILL_W'(WINDOW_LEN)) begin
                    if (CMP_W'(sum_next) >= CMP_W'(threshold)) begin
                        if (cnt_reg < CNT_W'(CONFIRM_WINDOWS)) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        if (cnt_next >= CNT_W'(CONFIRM_WINDOWS)) begin
                            flag_next = 1'b1;
                        end
                    end else begin
                        cnt_next = '0;
                    end
                end
            end
        end
    end

    assign confirmed_next = flag_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            idx_reg       <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            flag_reg      <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            have_prev_reg <= have_prev_next;
            prev_reg      <= prev_next;
            idx_reg       <= idx_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            flag_reg      <= flag_next;
            if (win_we) begin
                win_reg[idx_reg] <= delta;
            end
        end
    end

endmodule

// ===== hdl/motor_feedback_enable_detect.sv =====
// An accepted item passes through the input register, then the result register, before
// m_valid rises. Throughput: one item per cycle while the result register is empty or
// m_ready is high; rejected frames leave the input register with no result.
// The result register lets a new item enter while a result waits for m_ready.
// Reset (aresetn low, synchronous) clears valids, config registers and detector state.
// Top level of the motor feedback unpacker and enable detector; uses mfed_pkg, mfed_detect.
module motor_feedback_enable_detect import mfed_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    logic signed [OFFSET_W-1:0] offset_reg;
    logic [THRESH_W-1:0]        thresh_reg;
    logic                       det_en_reg;

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic      frame_ok;
    logic      out_free;
    logic      adv;
    logic      load_out;
    det_req_t  det_req;
    logic      confirmed_next;
    out_item_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            thresh_reg <= '0;
            det_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_POSITION_OFFSET:      offset_reg <= cfg_wdata[OFFSET_W-1:0];
                CFG_WINDOW_SUM_THRESHOLD: thresh_reg <= cfg_wdata[THRESH_W-1:0];
                CFG_DETECT_ENABLE:        det_en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign frame_ok = !in_data_reg.id_extended && (in_data_reg.byte_count == FRAME_BYTES);
    assign out_free = !out_valid_reg || m_ready;
    // a rejected frame leaves without needing the result register
    assign adv      = in_valid_reg && (!frame_ok || out_free);
    assign load_out = adv && frame_ok;
    assign s_ready  = !in_valid_reg || adv;

    assign det_req.strobe = load_out && det_en_reg;
    assign det_req.torque = in_data_reg.frame_bytes[27:16];

    mfed_detect u_detect (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req            (det_req),
        .threshold      (thresh_reg),
        .confirmed_next (confirmed_next)
    );

    always_comb begin
        result.motor_id        = in_data_reg.frame_bytes[63:56];
        result.position_code   = in_data_reg.frame_bytes[55:40];
        result.velocity_code   = in_data_reg.frame_bytes[39:28];
        result.torque_code     = in_data_reg.frame_bytes[27:16];
        result.temperature     = in_data_reg.frame_bytes[15:8];
        result.error_code      = in_data_reg.frame_bytes[7:0];
        result.offset_position = $signed({16'd0, in_data_reg.frame_bytes[55:40]}) + offset_reg;
        result.drive_active    = confirmed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (load_out) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== hdl/mfed_checker.sv =====
// Port-level checker for motor_feedback_enable_detect, attached by bind.
// Depends on mfed_pkg.
module mfed_checker import mfed_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             cfg_wr_en,
    input logic [1:0]       cfg_index,
    input logic [CFG_W-1:0] cfg_wdata,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input out_item_t        m_data
);

    logic [OFFSET_W-1:0] offset_reg;
    logic                seen_confirmed_reg;

    // shadow the offset register and remember a delivered confirmation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg         <= '0;
            seen_confirmed_reg <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_index == CFG_POSITION_OFFSET) begin
                offset_reg <= cfg_wdata[OFFSET_W-1:0];
            end
            if (m_valid && m_ready && m_data.drive_active) begin
                seen_confirmed_reg <= 1'b1;
            end
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_confirm_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_confirmed_reg && m_valid |-> m_data.drive_active)
        else $error("drive_active dropped after being reported");

    a_offset_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.offset_position == ({16'd0, m_data.position_code} + offset_reg))
        else $error("offset_position does not match position_code plus offset");

    // a result register that was empty only fills from an item that passed through the input register
    a_result_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared with no item in flight");

endmodule

bind motor_feedback_enable_detect mfed_checker u_mfed_checker (.*);
